[hdl/depq_pkg.sv]
// ----------------------------------------------------------------------------
// depq_pkg
// Shared types and defaults for the double-ended priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

package depq_pkg;

  localparam int unsigned DEPQ_CAPACITY  = 1024;
  localparam int unsigned DEPQ_KEY_WIDTH = 32;

  typedef enum logic [2:0] {
    MODE_INSERT  = 3'd0,
    MODE_EXT_MIN = 3'd1,
    MODE_EXT_MAX = 3'd2,
    MODE_CLEAR   = 3'd3,
    MODE_QUERY   = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EMPTY = 2'd1,
    STAT_FULL  = 2'd2
  } status_e;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INS_WR,
    ST_UP_RD,
    ST_UP_CMP,
    ST_UP_END,
    ST_DN_RL,
    ST_DN_RR,
    ST_DN_CMP,
    ST_X_RD0,
    ST_X_RD1,
    ST_X_SW,
    ST_X_RL,
    ST_X_RL2,
    ST_FIX_R1,
    ST_FIX_W1,
    ST_FIX_W2,
    ST_FIN,
    ST_FIN2,
    ST_OUT
  } state_e;

endpackage

`default_nettype wire

[hdl/depq_ram.sv]
// ----------------------------------------------------------------------------
// depq_ram
// Generic single-clock RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module depq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

[hdl/double_ended_priority_queue.sv]
// Path to m_axis_tvalid: clear, query and failed ops go from ST_IDLE through ST_FIN,
//   ST_FIN2 and ST_OUT; insert and extract first sift both heaps.
// Throughput: one beat at a time; set by the single read port of each heap RAM
//   (one heap level per read) plus a read-modify-write twin-link fix per swap.
// Reset: count and control clear at once; heap RAMs are not cleared (slots at
//   or beyond the count are never used). Input is taken while a result waits.
// ----------------------------------------------------------------------------
// double_ended_priority_queue
// Min/max queue from twin binary heaps in two RAMs, with cross links.
// ----------------------------------------------------------------------------
`default_nettype none

module double_ended_priority_queue import depq_pkg::*; #(
  parameter int unsigned CAPACITY  = DEPQ_CAPACITY,
  parameter int unsigned KEY_WIDTH = DEPQ_KEY_WIDTH
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // [2:0] mode, [34:3] value
  input  wire logic [39:0]  s_axis_tdata,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [1:0] status, [33:2] removed_value, [65:34] min_value, [97:66] max_value,
  // [108:98] entry_total, [109] queue_empty
  output logic      [111:0] m_axis_tdata
);

  localparam int unsigned AW = $clog2(CAPACITY);      // slot address
  localparam int unsigned CW = $clog2(CAPACITY + 1);  // count
  localparam int unsigned IW = AW + 2;                // child index
  localparam int unsigned EW = KEY_WIDTH + AW;
  localparam logic [KEY_WIDTH-1:0] KSIGN = {1'b1, {(KEY_WIDTH-1){1'b0}}};

  // Keys are stored biased (sign bit flipped) so unsigned order is signed order.
  typedef struct packed {
    logic [KEY_WIDTH-1:0] key;
    logic [AW-1:0]        lnk;
  } ent_t;

  function automatic logic better(logic max_heap, ent_t x, ent_t y);
    return max_heap ? (x.key > y.key) : (x.key < y.key);
  endfunction

  function automatic logic [31:0] key_out(logic [KEY_WIDTH-1:0] b);
    logic signed [KEY_WIDTH-1:0] k;
    k = signed'(b ^ KSIGN);
    return 32'(k);
  endfunction

  state_e               state_q, state_d, ret_q, ret_d;
  logic                 hs_q, hs_d;         // 0: working heap is the min heap
  logic                 phase_q, phase_d;   // second heap of the op
  logic                 ins_q, ins_d;
  logic [CW-1:0]        n_q, n_d;
  logic [AW-1:0]        i_q, i_d, pos_q, pos_d, ipos_q, ipos_d, twin_q, twin_d;
  logic [AW-1:0]        hwa_q, hwa_d, t1_q, t1_d, t2_q, t2_d, l1_q, l1_d, l2_q, l2_d;
  ent_t                 cur_q, cur_d, a_q, a_d, lch_q, lch_d, hwd_q, hwd_d;
  logic                 rv_q, rv_d;
  logic [1:0]           stat_q, stat_d;
  logic [31:0]          rem_q, rem_d;
  logic [KEY_WIDTH-1:0] key_q, key_d;
  logic [111:0]         res_q, res_d;
  logic                 mv_q;
  logic [111:0]         md_q;

  // RAM side
  ent_t          min_rd, max_rd, h_rd, o_rd;
  logic          h_we, h_re, o_we, o_re;
  logic [AW-1:0] h_wa, h_ra, o_wa, o_ra;
  ent_t          h_wd, o_wd;
  logic          min_we, min_re, max_we, max_re;
  logic [AW-1:0] min_wa, min_ra, max_wa, max_ra;
  ent_t          min_wd, max_wd;

  logic [CW-1:0] lim;
  logic [AW-1:0] last, par;
  logic [IW-1:0] lidx, ridx;
  logic          out_free;

  assign lim      = n_q - CW'(1);
  assign last     = lim[AW-1:0];
  assign par      = (i_q - AW'(1)) >> 1;
  assign lidx     = {1'b0, i_q, 1'b1};
  assign ridx     = lidx + IW'(1);
  assign out_free = !mv_q || m_axis_tready;

  assign h_rd = hs_q ? max_rd : min_rd;
  assign o_rd = hs_q ? min_rd : max_rd;

  assign s_axis_tready = (state_q == ST_IDLE);

  // next state and datapath
  always_comb begin
    ent_t best;
    logic [IW-1:0] bidx;
    logic bl;
    state_d = state_q;  ret_d = ret_q;  hs_d = hs_q;  phase_d = phase_q;
    ins_d = ins_q;  n_d = n_q;  i_d = i_q;  pos_d = pos_q;  ipos_d = ipos_q;
    twin_d = twin_q;  hwa_d = hwa_q;  hwd_d = hwd_q;  t1_d = t1_q;  t2_d = t2_q;
    l1_d = l1_q;  l2_d = l2_q;  cur_d = cur_q;  a_d = a_q;  lch_d = lch_q;
    rv_d = rv_q;  stat_d = stat_q;  rem_d = rem_q;  key_d = key_q;  res_d = res_q;
    best = cur_q;
    bidx = IW'(i_q);
    bl = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          stat_d = STAT_OK;
          rem_d = '0;
          key_d = KEY_WIDTH'(s_axis_tdata[34:3]) ^ KSIGN;
          phase_d = 1'b0;
          pos_d = '0;
          unique case (s_axis_tdata[2:0])
            MODE_INSERT: begin
              ins_d = 1'b1;
              if (n_q == CW'(CAPACITY)) begin
                stat_d = STAT_FULL;
                state_d = ST_FIN;
              end else begin
                state_d = ST_INS_WR;
              end
            end
            MODE_EXT_MIN, MODE_EXT_MAX: begin
              ins_d = 1'b0;
              hs_d = (s_axis_tdata[2:0] == MODE_EXT_MAX);
              if (n_q == '0) begin
                stat_d = STAT_EMPTY;
                state_d = ST_FIN;
              end else begin
                state_d = ST_X_RD0;
              end
            end
            MODE_CLEAR: begin
              n_d = '0;
              state_d = ST_FIN;
            end
            default: state_d = ST_FIN;  // query and unused modes
          endcase
        end
      end
      ST_INS_WR: begin
        cur_d = '{key: key_q, lnk: n_q[AW-1:0]};
        i_d = n_q[AW-1:0];
        ipos_d = n_q[AW-1:0];
        hs_d = 1'b0;
        n_d = n_q + CW'(1);
        state_d = ST_UP_RD;
      end
      ST_UP_RD: state_d = (i_q == '0) ? ST_UP_END : ST_UP_CMP;
      ST_UP_CMP: begin
        if (better(hs_q, cur_q, h_rd)) begin
          hwa_d = par;  hwd_d = cur_q;
          t1_d = h_rd.lnk;  l1_d = i_q;
          t2_d = cur_q.lnk;  l2_d = par;
          i_d = par;
          ret_d = ST_UP_RD;
          state_d = ST_FIX_R1;
        end else begin
          state_d = ST_UP_END;
        end
      end
      ST_UP_END: begin
        if (!phase_q) begin
          phase_d = 1'b1;
          hs_d = ~hs_q;
          if (ins_q) begin
            // reload the new entry from the max heap: its link moved with the
            // min heap sift
            pos_d = ipos_q;
            state_d = ST_X_RL;
          end else begin
            pos_d = twin_q;
            state_d = ST_X_RD0;
          end
        end else begin
          if (!ins_q) begin
            n_d = lim;
          end
          state_d = ST_FIN;
        end
      end
      ST_X_RD0: state_d = ST_X_RD1;
      ST_X_RD1: begin
        a_d = h_rd;
        if (!phase_q) begin
          rem_d = key_out(h_rd.key);
        end
        state_d = ST_X_SW;
      end
      ST_X_SW: begin
        twin_d = a_q.lnk;
        if (pos_q == last) begin
          state_d = ST_UP_END;
        end else begin
          hwa_d = last;  hwd_d = a_q;
          t1_d = h_rd.lnk;  l1_d = pos_q;
          t2_d = a_q.lnk;  l2_d = last;
          cur_d = h_rd;
          i_d = pos_q;
          ret_d = ST_DN_RL;
          state_d = ST_FIX_R1;
        end
      end
      ST_DN_RL: state_d = (lidx >= IW'(lim)) ? ST_X_RL : ST_DN_RR;
      ST_DN_RR: begin
        lch_d = h_rd;
        rv_d = (ridx < IW'(lim));
        state_d = ST_DN_CMP;
      end
      ST_DN_CMP: begin
        bl = better(hs_q, lch_q, cur_q);
        if (bl) begin
          best = lch_q;
          bidx = lidx;
        end
        if (rv_q && better(hs_q, h_rd, best)) begin
          best = h_rd;
          bidx = ridx;
          bl = 1'b1;
        end
        if (bl) begin
          hwa_d = bidx[AW-1:0];  hwd_d = cur_q;
          t1_d = best.lnk;  l1_d = i_q;
          t2_d = cur_q.lnk;  l2_d = bidx[AW-1:0];
          i_d = bidx[AW-1:0];
          ret_d = ST_DN_RL;
          state_d = ST_FIX_R1;
        end else begin
          state_d = ST_X_RL;
        end
      end
      ST_X_RL: state_d = ST_X_RL2;
      ST_X_RL2: begin
        cur_d = h_rd;
        i_d = pos_q;
        state_d = ST_UP_RD;
      end
      ST_FIX_R1: state_d = ST_FIX_W1;
      ST_FIX_W1: state_d = ST_FIX_W2;
      ST_FIX_W2: state_d = ret_q;
      ST_FIN:    state_d = ST_FIN2;
      ST_FIN2: begin
        res_d = {2'b00, (n_q == '0), 11'(n_q),
                 (n_q == '0) ? 32'd0 : key_out(max_rd.key),
                 (n_q == '0) ? 32'd0 : key_out(min_rd.key),
                 rem_q, stat_q};
        state_d = ST_OUT;
      end
      ST_OUT:    state_d = out_free ? ST_IDLE : ST_OUT;
      default:   state_d = ST_IDLE;
    endcase
  end

  // RAM port control
  always_comb begin
    h_we = 1'b0;  h_wa = '0;  h_wd = '0;  h_re = 1'b0;  h_ra = '0;
    o_we = 1'b0;  o_wa = '0;  o_wd = '0;  o_re = 1'b0;  o_ra = '0;
    unique case (state_q)
      ST_INS_WR: begin
        h_we = 1'b1;  h_wa = n_q[AW-1:0];  h_wd = '{key: key_q, lnk: n_q[AW-1:0]};
        o_we = 1'b1;  o_wa = n_q[AW-1:0];  o_wd = '{key: key_q, lnk: n_q[AW-1:0]};
      end
      ST_UP_RD: begin
        h_re = (i_q != '0);  h_ra = par;
      end
      ST_UP_CMP: begin
        h_we = better(hs_q, cur_q, h_rd);  h_wa = i_q;  h_wd = h_rd;
      end
      ST_X_RD0: begin
        h_re = 1'b1;  h_ra = pos_q;
      end
      ST_X_RD1: begin
        h_re = 1'b1;  h_ra = last;
      end
      ST_X_SW: begin
        h_we = (pos_q != last);  h_wa = pos_q;  h_wd = h_rd;
      end
      ST_DN_RL: begin
        h_re = 1'b1;  h_ra = lidx[AW-1:0];
      end
      ST_DN_RR: begin
        h_re = 1'b1;  h_ra = ridx[AW-1:0];
      end
      ST_DN_CMP: begin
        h_we = 1'b1;  h_wa = i_q;
        h_wd = (rv_q && better(hs_q, h_rd,
                 better(hs_q, lch_q, cur_q) ? lch_q : cur_q)) ? h_rd : lch_q;
        if (!better(hs_q, lch_q, cur_q)
            && !(rv_q && better(hs_q, h_rd, cur_q))) begin
          h_we = 1'b0;
        end
      end
      ST_X_RL: begin
        h_re = 1'b1;  h_ra = pos_q;
      end
      ST_FIX_R1: begin
        h_we = 1'b1;  h_wa = hwa_q;  h_wd = hwd_q;
        o_re = 1'b1;  o_ra = t1_q;
      end
      ST_FIX_W1: begin
        o_we = 1'b1;  o_wa = t1_q;  o_wd = '{key: o_rd.key, lnk: l1_q};
        o_re = 1'b1;  o_ra = t2_q;
      end
      ST_FIX_W2: begin
        o_we = 1'b1;  o_wa = t2_q;  o_wd = '{key: o_rd.key, lnk: l2_q};
      end
      ST_FIN: begin
        h_re = 1'b1;
        o_re = 1'b1;
      end
      default: ;
    endcase
  end

  assign min_we = hs_q ? o_we : h_we;
  assign min_wa = hs_q ? o_wa : h_wa;
  assign min_wd = hs_q ? o_wd : h_wd;
  assign min_re = hs_q ? o_re : h_re;
  assign min_ra = hs_q ? o_ra : h_ra;
  assign max_we = hs_q ? h_we : o_we;
  assign max_wa = hs_q ? h_wa : o_wa;
  assign max_wd = hs_q ? h_wd : o_wd;
  assign max_re = hs_q ? h_re : o_re;
  assign max_ra = hs_q ? h_ra : o_ra;

  depq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_min_ram (
    .clk_i   (clk_i),
    .we_i    (min_we),
    .waddr_i (min_wa),
    .wdata_i (min_wd),
    .re_i    (min_re),
    .raddr_i (min_ra),
    .rdata_o (min_rd)
  );

  depq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_max_ram (
    .clk_i   (clk_i),
    .we_i    (max_we),
    .waddr_i (max_wa),
    .wdata_i (max_wd),
    .re_i    (max_re),
    .raddr_i (max_ra),
    .rdata_o (max_rd)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ret_q   <= ST_IDLE;
      hs_q    <= 1'b0;
      phase_q <= 1'b0;
      ins_q   <= 1'b0;
      n_q     <= '0;
      mv_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      hs_q    <= hs_d;
      phase_q <= phase_d;
      ins_q   <= ins_d;
      n_q     <= n_d;
      if (state_q == ST_OUT && out_free) begin
        mv_q <= 1'b1;
      end else if (m_axis_tready) begin
        mv_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    i_q <= i_d;  pos_q <= pos_d;  ipos_q <= ipos_d;  twin_q <= twin_d;
    hwa_q <= hwa_d;  hwd_q <= hwd_d;  t1_q <= t1_d;  t2_q <= t2_d;
    l1_q <= l1_d;  l2_q <= l2_d;  cur_q <= cur_d;  a_q <= a_d;  lch_q <= lch_d;
    rv_q <= rv_d;  stat_q <= stat_d;  rem_q <= rem_d;  key_q <= key_d;
    res_q <= res_d;
    if (state_q == ST_OUT && out_free) begin
      md_q <= res_q;
    end
  end

  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;

endmodule

`default_nettype wire

[hdl/depq_check.sv]
// ----------------------------------------------------------------------------
// depq_check
// Port-level checks for the double-ended priority queue.
// ----------------------------------------------------------------------------
`default_nettype none

module depq_check import depq_pkg::*; #(
  parameter int unsigned CAPACITY = DEPQ_CAPACITY
) (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [111:0] m_axis_tdata
);

  // one input beat at a time
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("input taken while busy");

  // stalled result beat holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[109] == (m_axis_tdata[108:98] == 11'd0)))
    else $error("empty flag disagrees with count");

  a_empty_keys: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[109] |-> m_axis_tdata[97:34] == 64'd0)
    else $error("min/max nonzero on empty queue");

  a_count_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[108:98] <= 11'(CAPACITY))
    else $error("count beyond capacity");

endmodule

bind double_ended_priority_queue depq_check #(.CAPACITY(CAPACITY)) u_depq_check (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the double-ended priority queue: a directed table
// followed by random runs over all modes, all checked against a behavioral
// twin-heap model kept in the bench, with bursty input and stalling output.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;
  import depq_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CAP       = DEPQ_CAPACITY;
  localparam int unsigned WDOG_LIMIT = 200000;
  localparam int unsigned N_RANDOM  = 450;
  localparam int unsigned DRAIN_CYC = 400;

  // packed from the top bit down, so status lands in the low bits of tdata
  typedef struct packed {
    logic        empty;
    logic [10:0] total;
    logic [31:0] max_v;
    logic [31:0] min_v;
    logic [31:0] removed;
    logic [1:0]  status;
  } qresult_t;

  typedef struct {
    logic [2:0]  mode;
    logic [31:0] value;
    bit          has_exp;
    qresult_t    exp_res;
  } dir_row_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  // [2:0] mode, [34:3] value
  logic [39:0]  s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  // [1:0] status, [33:2] removed_value, [65:34] min_value, [97:66] max_value,
  // [108:98] entry_total, [109] queue_empty
  logic [111:0] m_axis_tdata;

  double_ended_priority_queue u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Bench model of the queue. Keys are stored biased (sign bit flipped) so
  // unsigned compare gives signed order, same as the hardware.
  logic [31:0] mn_key [CAP];
  int unsigned mn_lnk [CAP];
  logic [31:0] mx_key [CAP];
  int unsigned mx_lnk [CAP];
  int unsigned held;

  qresult_t pending_q[$];
  bit       failed;
  int unsigned n_seen;

  function automatic bit key_better(bit is_min, logic [31:0] a, logic [31:0] b);
    return is_min ? (a < b) : (a > b);
  endfunction

  // Swap slots i and j in one heap, fixing twin links in the other.
  function automatic void heap_swap(bit is_min, int unsigned i, int unsigned j);
    int unsigned ti, tj, l;
    logic [31:0] k;
    if (is_min) begin
      ti = mn_lnk[i]; tj = mn_lnk[j];
      l = mx_lnk[ti]; mx_lnk[ti] = mx_lnk[tj]; mx_lnk[tj] = l;
      k = mn_key[i]; mn_key[i] = mn_key[j]; mn_key[j] = k;
      l = mn_lnk[i]; mn_lnk[i] = mn_lnk[j]; mn_lnk[j] = l;
    end else begin
      ti = mx_lnk[i]; tj = mx_lnk[j];
      l = mn_lnk[ti]; mn_lnk[ti] = mn_lnk[tj]; mn_lnk[tj] = l;
      k = mx_key[i]; mx_key[i] = mx_key[j]; mx_key[j] = k;
      l = mx_lnk[i]; mx_lnk[i] = mx_lnk[j]; mx_lnk[j] = l;
    end
  endfunction

  function automatic logic [31:0] key_at(bit is_min, int unsigned i);
    return is_min ? mn_key[i] : mx_key[i];
  endfunction

  function automatic void heap_down(bit is_min, int unsigned n, int unsigned i);
    int unsigned l, r, best;
    forever begin
      l = 2*i + 1; r = 2*i + 2; best = i;
      if (l < n && key_better(is_min, key_at(is_min, l), key_at(is_min, best))) best = l;
      if (r < n && key_better(is_min, key_at(is_min, r), key_at(is_min, best))) best = r;
      if (best == i) break;
      heap_swap(is_min, i, best);
      i = best;
    end
  endfunction

  function automatic void heap_up(bit is_min, int unsigned i);
    while (i > 0 && key_better(is_min, key_at(is_min, i), key_at(is_min, (i-1)/2))) begin
      heap_swap(is_min, i, (i-1)/2);
      i = (i-1)/2;
    end
  endfunction

  function automatic void heap_remove(bit is_min, int unsigned n, int unsigned pos);
    heap_swap(is_min, pos, n-1);
    if (pos < n-1) begin
      heap_down(is_min, n-1, pos);
      heap_up(is_min, pos);
    end
  endfunction

  function automatic qresult_t queue_step(logic [2:0] mode, logic [31:0] value);
    qresult_t    res;
    int unsigned n;
    bit          from_min;
    int unsigned twin;
    n = held;
    res = '0;
    res.status = STAT_OK;
    case (mode)
      MODE_INSERT: begin
        if (n >= CAP) begin
          res.status = STAT_FULL;
        end else begin
          mn_key[n] = value ^ 32'h8000_0000; mn_lnk[n] = n;
          mx_key[n] = value ^ 32'h8000_0000; mx_lnk[n] = n;
          n++;
          heap_up(1'b1, n-1);
          heap_up(1'b0, n-1);
        end
      end
      MODE_EXT_MIN, MODE_EXT_MAX: begin
        if (n == 0) begin
          res.status = STAT_EMPTY;
        end else begin
          from_min = (mode == MODE_EXT_MIN);
          res.removed = key_at(from_min, 0) ^ 32'h8000_0000;
          heap_remove(from_min, n, 0);
          // twin of the removed entry now sits behind the root's old link
          twin = from_min ? mn_lnk[n-1] : mx_lnk[n-1];
          heap_remove(!from_min, n, twin);
          n--;
        end
      end
      MODE_CLEAR: n = 0;
      default: ;
    endcase
    held = n;
    if (n != 0) begin
      res.min_v = mn_key[0] ^ 32'h8000_0000;
      res.max_v = mx_key[0] ^ 32'h8000_0000;
    end
    res.total = n[10:0];
    res.empty = (n == 0);
    return res;
  endfunction

  // Directed table: expected typed in only where obvious.
  dir_row_t dir_rows[$];

  function automatic qresult_t mk_res(logic [1:0] st, logic [31:0] rm, logic [31:0] mi,
                                      logic [31:0] ma, logic [10:0] tot, logic emp);
    qresult_t r;
    r.status = st; r.removed = rm; r.min_v = mi; r.max_v = ma;
    r.total = tot; r.empty = emp;
    return r;
  endfunction

  function automatic void add_row(logic [2:0] m, logic [31:0] v, bit he, qresult_t e);
    dir_row_t r;
    r.mode = m; r.value = v; r.has_exp = he; r.exp_res = e;
    dir_rows.push_back(r);
  endfunction

  function automatic void build_table();
    qresult_t z;
    z = '0;
    add_row(MODE_QUERY,   32'h0, 1, mk_res(STAT_OK, 0, 0, 0, 0, 1));
    add_row(MODE_EXT_MIN, 32'h0, 1, mk_res(STAT_EMPTY, 0, 0, 0, 0, 1));
    add_row(MODE_EXT_MAX, 32'hFFFF_FFFF, 1, mk_res(STAT_EMPTY, 0, 0, 0, 0, 1));
    add_row(MODE_INSERT,  32'h8000_0000, 1,
            mk_res(STAT_OK, 0, 32'h8000_0000, 32'h8000_0000, 1, 0));
    add_row(MODE_INSERT,  32'h7FFF_FFFF, 1,
            mk_res(STAT_OK, 0, 32'h8000_0000, 32'h7FFF_FFFF, 2, 0));
    add_row(MODE_INSERT,  32'h0, 0, z);
    add_row(MODE_INSERT,  32'hFFFF_FFFF, 0, z);
    add_row(MODE_INSERT,  32'h0, 0, z);            // equal keys
    add_row(MODE_INSERT,  32'h0000_0005, 0, z);
    add_row(MODE_EXT_MAX, 32'h1234_5678, 0, z);
    add_row(MODE_EXT_MIN, 32'h0, 0, z);
    add_row(3'd5,         32'h0, 0, z);            // unused modes act as query
    add_row(3'd6,         32'hFFFF_FFFF, 0, z);
    add_row(3'd7,         32'h0, 0, z);
    add_row(MODE_EXT_MIN, 32'h0, 0, z);
    add_row(MODE_CLEAR,   32'h0, 1, mk_res(STAT_OK, 0, 0, 0, 0, 1));
    add_row(MODE_EXT_MAX, 32'h0, 1, mk_res(STAT_EMPTY, 0, 0, 0, 0, 1));
    add_row(MODE_INSERT,  32'h8000_0000, 0, z);
    add_row(MODE_INSERT,  32'h8000_0000, 0, z);
    add_row(MODE_EXT_MAX, 32'h0, 0, z);
    add_row(MODE_EXT_MAX, 32'h0, 0, z);
    add_row(MODE_QUERY,   32'h0, 0, z);
  endfunction

  // Receiver: stalls on its own pattern (long stalls, short stalls, none).
  int unsigned rx_phase;

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      rx_phase++;
      case ((rx_phase / 300) % 3)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        default: m_axis_tready <= ((rx_phase % 7) < 2);
      endcase
    end
  end

  int unsigned idle_cyc;

  always @(posedge clk_i) begin
    qresult_t got, want;
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cyc <= 0;
      end else begin
        idle_cyc <= idle_cyc + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = m_axis_tdata[109:0];
        if (pending_q.size() == 0) begin
          $display("%0t: result beat with nothing expected, actual %h", $realtime, got);
          failed = 1;
        end else begin
          want = pending_q.pop_front();
          n_seen++;
          if (got.status !== want.status)
            $display("%0t: status exp %0d act %0d", $realtime, want.status, got.status);
          if (got.removed !== want.removed)
            $display("%0t: removed exp %h act %h", $realtime, want.removed, got.removed);
          if (got.min_v !== want.min_v)
            $display("%0t: min exp %h act %h", $realtime, want.min_v, got.min_v);
          if (got.max_v !== want.max_v)
            $display("%0t: max exp %h act %h", $realtime, want.max_v, got.max_v);
          if (got.total !== want.total)
            $display("%0t: total exp %0d act %0d", $realtime, want.total, got.total);
          if (got.empty !== want.empty)
            $display("%0t: empty exp %0d act %0d", $realtime, want.empty, got.empty);
          if (got !== want) failed = 1;
        end
      end
      if (idle_cyc >= WDOG_LIMIT) begin
        $display("%0t: watchdog, no beat for %0d cycles", $realtime, WDOG_LIMIT);
        $display("tb NOT OK");
        $finish;
      end
    end
  end

  // Send one beat; waits for acceptance. The model result goes to the queue
  // at the accepting edge, so ordering against the checker is by edge.
  task automatic send_beat(input logic [2:0] mode, input logic [31:0] value,
                           input bit has_exp, input qresult_t exp_res);
    qresult_t pred;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {5'b0, value, mode};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    pred = queue_step(mode, value);
    if (has_exp && pred !== exp_res) begin
      $display("%0t: table row mode %0d exp %h model %h", $realtime, mode, exp_res, pred);
      failed = 1;
    end
    pending_q.push_back(has_exp ? exp_res : pred);
    @(negedge clk_i);
  endtask

  // Burst gaps: valid drops between bursts only.
  int unsigned burst_left;

  task automatic maybe_gap();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 60)) @(negedge clk_i);
    end
    burst_left--;
  endtask

  function automatic logic [31:0] rand_key();
    case ($urandom_range(0, 5))
      0: return 32'h8000_0000 + $urandom_range(0, 3);
      1: return 32'h7FFF_FFFF - $urandom_range(0, 3);
      2: return $urandom_range(0, 7);          // many duplicates
      default: return $urandom();
    endcase
  endfunction

  initial begin
    qresult_t    z;
    logic [2:0]  m;
    int unsigned r, sent, wait_cyc;
    z = '0;
    failed = 0; n_seen = 0; held = 0; rx_phase = 0; idle_cyc = 0; burst_left = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    rst_ni = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    build_table();
    foreach (dir_rows[i]) begin
      maybe_gap();
      send_beat(dir_rows[i].mode, dir_rows[i].value, dir_rows[i].has_exp, dir_rows[i].exp_res);
    end

    // Random: mostly inserts early to grow the heaps, then mixed.
    for (sent = 0; sent < N_RANDOM; sent++) begin
      maybe_gap();
      if (sent == N_RANDOM / 2) begin
        // hold off until every result is back
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(negedge clk_i);
      end
      r = $urandom_range(0, 99);
      if (sent < 150)      m = (r < 70) ? MODE_INSERT : (r < 83 ? MODE_EXT_MIN : MODE_EXT_MAX);
      else if (r < 45)     m = MODE_INSERT;
      else if (r < 70)     m = MODE_EXT_MIN;
      else if (r < 94)     m = MODE_EXT_MAX;
      else if (r < 96)     m = MODE_CLEAR;
      else                 m = (r < 98) ? MODE_QUERY : 3'($urandom_range(5, 7));
      send_beat(m, (m == MODE_INSERT) ? rand_key() : $urandom(), 0, z);
    end
    s_axis_tvalid <= 1'b0;

    wait_cyc = 0;
    while (pending_q.size() != 0 && wait_cyc < WDOG_LIMIT) begin
      @(negedge clk_i);
      wait_cyc++;
    end
    repeat (DRAIN_CYC) @(negedge clk_i);
    if (!failed && pending_q.size() == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule

`default_nettype wire
